// ===== design/fdsg_pkg.sv =====
`default_nettype none

package fdsg_pkg;

	// default coordinate width of the centre ports
	localparam int COORD_BITS_DEF = 16;

	localparam int RADIUS_BITS = 14;
	localparam int OFFS_BITS   = 15;
	localparam int ERR_BITS    = 20;

	// decision error: starts at 5 - 4*r, y step subtracts 8*y, x step adds 4 + 8*x
	localparam int ERR_INIT     = 5;
	localparam int ERR_STEP_ADD = 4;
	localparam int ERR_OFF_SHL  = 3;
	localparam int ERR_RAD_SHL  = 2;

	localparam int QUEUE_DEPTH = 2;

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// span order within one iteration
	localparam logic [1:0] SPAN_TOP_OUTER = 2'd0;
	localparam logic [1:0] SPAN_TOP_INNER = 2'd1;
	localparam logic [1:0] SPAN_BOT_INNER = 2'd2;
	localparam logic [1:0] SPAN_BOT_OUTER = 2'd3;

	typedef struct packed {
		logic full;
		logic nonempty;
	} queue_stat_t;

	// job word: cx, cy, x, y, last, single
	function automatic int job_bits(int coord_bits);
		return 2 * coord_bits + 2 * OFFS_BITS + 2;
	endfunction

endpackage

`default_nettype wire

// ===== design/fdsg_queue.sv =====
`default_nettype none

module fdsg_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = fdsg_pkg::QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic                 pop,
	output logic      [WIDTH-1:0]     rdata,
	output fdsg_pkg::queue_stat_t     stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign rdata         = entry_q[rd_ptr_q];
	assign stat.full     = (count_q == CNT_W'(DEPTH));
	assign stat.nonempty = (count_q != '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!stat.full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> stat.nonempty)
		else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== design/fdsg_front.sv =====
`default_nettype none

module fdsg_front #(
	parameter int COORD_BITS = fdsg_pkg::COORD_BITS_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      item_valid,
	output logic                                           item_stall,
	input  wire logic                                      operation,
	input  wire logic signed [COORD_BITS-1:0]              center_x,
	input  wire logic signed [COORD_BITS-1:0]              center_y,
	input  wire logic [fdsg_pkg::RADIUS_BITS-1:0]          radius,
	input  wire fdsg_pkg::queue_stat_t                     q_stat,
	output logic                                           push,
	output logic [fdsg_pkg::job_bits(COORD_BITS)-1:0]      job_data
);

	localparam int OB = fdsg_pkg::OFFS_BITS;
	localparam int EB = fdsg_pkg::ERR_BITS;

	typedef struct packed {
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
		logic [OB-1:0]         x;
		logic [OB-1:0]         y;
		logic                  last;
		logic                  single;
	} job_t;

	logic [COORD_BITS-1:0] ccol_q;
	logic [COORD_BITS-1:0] crow_q;
	logic [OB-1:0]         x_q;
	logic [OB-1:0]         y_q;
	logic [EB-1:0]         err_q;
	logic                  active_q;
	logic                  single_q;

	logic          accept;
	logic          err_pos;
	logic [OB-1:0] x_n;
	logic [OB-1:0] y_n;
	logic [EB-1:0] err_dec;
	logic [EB-1:0] err_n;
	logic          done;
	job_t          job;

	assign item_stall = q_stat.full;
	assign accept     = item_valid && !item_stall;

	// one midpoint iteration
	assign err_pos = !err_q[EB-1] && (err_q != '0);
	assign y_n     = err_pos ? (y_q - OB'(1)) : y_q;
	assign x_n     = x_q + OB'(1);
	assign err_dec = err_pos ? (err_q - (EB'(y_n) << fdsg_pkg::ERR_OFF_SHL)) : err_q;
	assign err_n   = err_dec + (EB'(x_n) << fdsg_pkg::ERR_OFF_SHL)
		+ EB'(fdsg_pkg::ERR_STEP_ADD);
	assign done    = (x_n > y_n);

	assign push = accept && (operation == fdsg_pkg::OP_STEP) && active_q;

	always_comb begin
		job.cx     = ccol_q;
		job.cy     = crow_q;
		job.x      = x_q;
		job.y      = y_q;
		job.single = single_q;
		job.last   = single_q || done;
	end

	assign job_data = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccol_q   <= '0;
			crow_q   <= '0;
			x_q      <= '0;
			y_q      <= '0;
			err_q    <= '0;
			active_q <= 1'b0;
			single_q <= 1'b0;
		end else if (accept) begin
			if (operation == fdsg_pkg::OP_LOAD) begin
				ccol_q   <= center_x;
				crow_q   <= center_y;
				x_q      <= '0;
				y_q      <= OB'(radius);
				err_q    <= EB'(fdsg_pkg::ERR_INIT) - (EB'(radius) << fdsg_pkg::ERR_RAD_SHL);
				single_q <= (radius == '0);
				active_q <= 1'b1;
			end else if (active_q) begin
				if (single_q) begin
					active_q <= 1'b0;
					single_q <= 1'b0;
				end else begin
					x_q   <= x_n;
					y_q   <= y_n;
					err_q <= err_n;
					if (done) begin
						active_q <= 1'b0;
					end
				end
			end
		end
	end

	a_last_ends_disk: assert property (@(posedge clk) disable iff (!arst_n)
		(push && job.last) |=> !active_q)
		else $error("disk still active after its last job");

endmodule

`default_nettype wire

// ===== design/fdsg_back.sv =====
`default_nettype none

module fdsg_back #(
	parameter int COORD_BITS = fdsg_pkg::COORD_BITS_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic [fdsg_pkg::job_bits(COORD_BITS)-1:0] job_data,
	input  wire fdsg_pkg::queue_stat_t                     q_stat,
	output logic                                           pop,
	output logic                                           span_valid,
	input  wire logic                                      span_stall,
	output logic signed [COORD_BITS:0]                     span_left,
	output logic signed [COORD_BITS:0]                     span_right,
	output logic signed [COORD_BITS:0]                     span_row,
	output logic                                           last_span
);

	localparam int OB = fdsg_pkg::OFFS_BITS;
	localparam int OW = COORD_BITS + 1;

	typedef struct packed {
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
		logic [OB-1:0]         x;
		logic [OB-1:0]         y;
		logic                  last;
		logic                  single;
	} job_t;

	job_t          job;
	logic [1:0]    idx_q;
	logic [1:0]    finish_idx;
	logic          adv;
	logic [OW-1:0] cx_e;
	logic [OW-1:0] cy_e;
	logic [OW-1:0] x_e;
	logic [OW-1:0] y_e;
	logic [OW-1:0] col_off;
	logic [OW-1:0] row_n;
	logic          last_n;

	logic          valid_q;
	logic [OW-1:0] left_q;
	logic [OW-1:0] right_q;
	logic [OW-1:0] row_q;
	logic          last_q;

	assign job  = job_t'(job_data);
	assign cx_e = OW'($signed(job.cx));
	assign cy_e = OW'($signed(job.cy));
	assign x_e  = OW'(job.x);
	assign y_e  = OW'(job.y);

	// a zero-radius job carries x = y = 0, so the top outer span is the point
	assign finish_idx = job.single ? fdsg_pkg::SPAN_TOP_OUTER : fdsg_pkg::SPAN_BOT_OUTER;
	assign adv        = q_stat.nonempty && (!valid_q || !span_stall);
	assign pop        = adv && (idx_q == finish_idx);

	always_comb begin
		unique case (idx_q)
			fdsg_pkg::SPAN_TOP_OUTER: begin
				col_off = x_e;
				row_n   = cy_e - y_e;
			end
			fdsg_pkg::SPAN_TOP_INNER: begin
				col_off = y_e;
				row_n   = cy_e - x_e;
			end
			fdsg_pkg::SPAN_BOT_INNER: begin
				col_off = y_e;
				row_n   = cy_e + x_e;
			end
			default: begin
				col_off = x_e;
				row_n   = cy_e + y_e;
			end
		endcase
		last_n = (idx_q == finish_idx) && job.last;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_q  <= cx_e - col_off;
			right_q <= cx_e + col_off;
			row_q   <= row_n;
			last_q  <= last_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= fdsg_pkg::SPAN_TOP_OUTER;
		end else begin
			if (adv) begin
				valid_q <= 1'b1;
				idx_q   <= pop ? fdsg_pkg::SPAN_TOP_OUTER : idx_q + 2'd1;
			end else if (!span_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign span_valid = valid_q;
	assign span_left  = $signed(left_q);
	assign span_right = $signed(right_q);
	assign span_row   = $signed(row_q);
	assign last_span  = last_q;

	a_mid_job_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != fdsg_pkg::SPAN_TOP_OUTER) |-> q_stat.nonempty)
		else $error("span index mid-job with no job queued");

endmodule

`default_nettype wire

// ===== design/filled_disk_span_generator.sv =====
// Filled disk span generator: rasterizes a disk as horizontal spans with the
// integer midpoint circle rule.
// Input channel (item_valid / item_stall): a load beat (operation = 0) latches
// center_x, center_y and radius and yields nothing; a step beat (operation = 1)
// runs one octant iteration and yields four span beats in the order top outer,
// top inner, bottom inner, bottom outer. Radius zero gives one one-pixel span.
// The disk's final span carries last_span. Steps while idle give nothing.
// Output channel (span_valid / span_stall): one beat per span, from a register.
// A step's jobs pass through the job queue and the span output register. The
// span port moves one beat per cycle while span_stall is low, and a two-entry
// job queue between the iteration front end and the span emitter lets steps
// and loads run ahead of the output.
// Loads are taken every cycle unless the queue is full.
// When the receiver stalls, the held span stays put, the queue fills, and then
// item_stall rises. Reset empties the queue and leaves the block idle.
`default_nettype none

module filled_disk_span_generator #(
	parameter int COORD_BITS = fdsg_pkg::COORD_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic                             operation,
	input  wire logic signed [COORD_BITS-1:0]     center_x,
	input  wire logic signed [COORD_BITS-1:0]     center_y,
	input  wire logic [fdsg_pkg::RADIUS_BITS-1:0] radius,
	output logic                                  span_valid,
	input  wire logic                             span_stall,
	output logic signed [COORD_BITS:0]            span_left,
	output logic signed [COORD_BITS:0]            span_right,
	output logic signed [COORD_BITS:0]            span_row,
	output logic                                  last_span
);

	localparam int JOB_W = fdsg_pkg::job_bits(COORD_BITS);

	// front end -> queue
	logic             push;
	logic [JOB_W-1:0] job_in;
	// queue -> back end
	logic             pop;
	logic [JOB_W-1:0] job_head;
	fdsg_pkg::queue_stat_t q_stat;

	fdsg_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.operation  (operation),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius     (radius),
		.q_stat     (q_stat),
		.push       (push),
		.job_data   (job_in)
	);

	fdsg_queue #(
		.WIDTH(JOB_W),
		.DEPTH(fdsg_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.pop    (pop),
		.rdata  (job_head),
		.stat   (q_stat)
	);

	fdsg_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_data   (job_head),
		.q_stat     (q_stat),
		.pop        (pop),
		.span_valid (span_valid),
		.span_stall (span_stall),
		.span_left  (span_left),
		.span_right (span_right),
		.span_row   (span_row),
		.last_span  (last_span)
	);

endmodule

`default_nettype wire

// ===== sim/filled_disk_span_checker.sv =====
module filled_disk_span_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    item_valid,
	input  logic                                    item_stall,
	input  logic                                    operation,
	input  logic signed [fdsg_pkg::COORD_BITS_DEF-1:0] center_x,
	input  logic signed [fdsg_pkg::COORD_BITS_DEF-1:0] center_y,
	input  logic [fdsg_pkg::RADIUS_BITS-1:0]        radius,
	input  logic                                    span_valid,
	input  logic                                    span_stall,
	input  logic signed [fdsg_pkg::COORD_BITS_DEF:0]   span_left,
	input  logic signed [fdsg_pkg::COORD_BITS_DEF:0]   span_right,
	input  logic signed [fdsg_pkg::COORD_BITS_DEF:0]   span_row,
	input  logic                                    last_span,
	output int                                      error_count,
	output int                                      pending,
	output int                                      span_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import fdsg_pkg::*;

	localparam int CB       = COORD_BITS_DEF;
	localparam int OUT_BITS = CB + 1;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] left;
		logic signed [OUT_BITS-1:0] right;
		logic signed [OUT_BITS-1:0] row;
		logic                       last;
	} span_beat_t;

	// predicted rasterizer state
	logic signed [CB-1:0]       disk_col;
	logic signed [CB-1:0]       disk_row;
	logic [OFFS_BITS-1:0]       col_step;
	logic [OFFS_BITS-1:0]       row_height;
	logic signed [ERR_BITS-1:0] midpoint_err;
	logic                       disk_active;
	logic                       one_pixel;

	span_beat_t spans_due[$];
	span_beat_t want;
	int         fails;
	int         seen_spans;

	task automatic push_span(input int left, input int right, input int row, input logic last);
		span_beat_t s;
		s.left  = OUT_BITS'(left);
		s.right = OUT_BITS'(right);
		s.row   = OUT_BITS'(row);
		s.last  = last;
		spans_due.push_back(s);
	endtask

	// one accepted input beat -> zero, one or four expected spans
	task automatic rasterize_item(input logic op, input logic signed [CB-1:0] cx,
			input logic signed [CB-1:0] cy, input logic [RADIUS_BITS-1:0] r);
		int cxi, cyi, xi, yi, e, ri;
		logic done;
		if (op == OP_LOAD) begin
			ri           = int'(r);
			disk_col     = cx;
			disk_row     = cy;
			col_step     = '0;
			row_height   = OFFS_BITS'(r);
			midpoint_err = ERR_BITS'(ERR_INIT - (ri << ERR_RAD_SHL));
			one_pixel    = (r == 0);
			disk_active  = 1'b1;
		end else if (disk_active) begin
			cxi = int'(disk_col);
			cyi = int'(disk_row);
			if (one_pixel) begin
				push_span(cxi, cxi, cyi, 1'b1);
				disk_active = 1'b0;
				one_pixel   = 1'b0;
			end else begin
				xi = int'(col_step);
				yi = int'(row_height);
				e  = int'(midpoint_err);
				if (e > 0) begin
					row_height = OFFS_BITS'(yi - 1);
					e = e - ((yi - 1) << ERR_OFF_SHL);
				end
				col_step     = OFFS_BITS'(xi + 1);
				e            = e + ERR_STEP_ADD + ((xi + 1) << ERR_OFF_SHL);
				midpoint_err = ERR_BITS'(e);
				done         = (col_step > row_height);
				push_span(cxi - xi, cxi + xi, cyi - yi, 1'b0);
				push_span(cxi - yi, cxi + yi, cyi - xi, 1'b0);
				push_span(cxi - yi, cxi + yi, cyi + xi, 1'b0);
				push_span(cxi - xi, cxi + xi, cyi + yi, done);
				if (done)
					disk_active = 1'b0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_col     = '0;
			disk_row     = '0;
			col_step     = '0;
			row_height   = '0;
			midpoint_err = '0;
			disk_active  = 1'b0;
			one_pixel    = 1'b0;
			spans_due.delete();
			fails        = 0;
			seen_spans   = 0;
			error_count <= 0;
			pending     <= 0;
			span_count  <= 0;
		end else begin
			if (span_valid && !span_stall) begin
				seen_spans++;
				if (spans_due.size() == 0) begin
					fails++;
					$display("%0t: expected no span, got %0d..%0d row %0d last %0b",
						$time, span_left, span_right, span_row, last_span);
				end else begin
					want = spans_due.pop_front();
					if (want.left !== span_left || want.right !== span_right ||
							want.row !== span_row || want.last !== last_span) begin
						fails++;
						$display("%0t: expected %0d..%0d row %0d last %0b, got %0d..%0d row %0d last %0b",
							$time, $signed(want.left), $signed(want.right),
							$signed(want.row), want.last,
							span_left, span_right, span_row, last_span);
					end
				end
			end
			if (item_valid && !item_stall)
				rasterize_item(operation, center_x, center_y, radius);
			error_count <= fails;
			pending     <= spans_due.size();
			span_count  <= seen_spans;
		end
	end

endmodule

// ===== sim/filled_disk_span_generator_test.sv =====
module filled_disk_span_generator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fdsg_pkg::*;

	localparam int CB          = COORD_BITS_DEF;
	localparam int CYCLE_LIMIT = 200000;  // watchdog bound on the whole run
	localparam int HOLD_CYCLES = 200;     // long receiver hold-off
	localparam int DRAIN_TAIL  = 20;      // quiet cycles after the last span

	logic                   clk;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_stall;
	logic                   operation;
	logic signed [CB-1:0]   center_x;
	logic signed [CB-1:0]   center_y;
	logic [RADIUS_BITS-1:0] radius;
	logic                   span_valid;
	logic                   span_stall;
	logic signed [CB:0]     span_left;
	logic signed [CB:0]     span_right;
	logic signed [CB:0]     span_row;
	logic                   last_span;

	int error_count;
	int pending;
	int span_count;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int hold_served;
	int cycle_count;
	int beats_sent;
	int loads_sent;
	int useful_items;

	filled_disk_span_generator #(.COORD_BITS(CB)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.operation  (operation),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius     (radius),
		.span_valid (span_valid),
		.span_stall (span_stall),
		.span_left  (span_left),
		.span_right (span_right),
		.span_row   (span_row),
		.last_span  (last_span)
	);

	// watches both channels, predicts every span and compares
	filled_disk_span_checker span_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.operation   (operation),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.span_valid  (span_valid),
		.span_stall  (span_stall),
		.span_left   (span_left),
		.span_right  (span_right),
		.span_row    (span_row),
		.last_span   (last_span),
		.error_count (error_count),
		.pending     (pending),
		.span_count  (span_count)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Receiver side: random stall per cycle, or a long hold-off when the
	// stimulus asks for one. Requests are counted so the two processes never
	// race on a shared flag.
	always begin
		@(posedge clk);
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			span_stall <= 1'b1;
			for (int n = 0; n < HOLD_CYCLES; n++)
				@(posedge clk);
		end else begin
			span_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Offer one input beat and hold it until it is taken. An idle gap lowers
	// valid first; back-to-back beats keep valid high, so valid gets only one
	// nonblocking assignment per edge.
	task automatic send_item(input logic op, input logic signed [CB-1:0] cx,
			input logic signed [CB-1:0] cy, input logic [RADIUS_BITS-1:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		operation  <= op;
		center_x   <= cx;
		center_y   <= cy;
		radius     <= r;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		beats_sent++;
		if (op == OP_LOAD)
			loads_sent++;
	endtask

	// load a disk, then a number of steps; too few abandons it, too many
	// runs into idle steps
	task automatic draw_disk(input int cx, input int cy, input int r, input int steps);
		send_item(OP_LOAD, CB'(cx), CB'(cy), RADIUS_BITS'(r));
		for (int i = 0; i < steps; i++)
			send_item(OP_STEP, CB'($urandom), CB'($urandom), RADIUS_BITS'($urandom));
		useful_items += 1 + steps;
	endtask

	// sender goes quiet until every predicted span has come out; pending
	// is registered in the checker, so wait for a clock edge before each look
	task automatic wait_drained();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic random_phase(input int send_pct, input int recv_pct, input int quota);
		int target;
		int r;
		int n;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = useful_items + quota;
		while (useful_items < target) begin
			if ($urandom_range(99) < 80) begin
				if ($urandom_range(19) == 0) begin
					// big radius, a few steps, then dropped by the next load
					r = $urandom_range(16383);
					n = $urandom_range(8, 3);
				end else begin
					r = $urandom_range(40);
					n = r * 3 / 4 + 2;   // enough to finish the disk
					if ($urandom_range(4) == 0)
						n = $urandom_range(n);
				end
				draw_disk($urandom, $urandom, r, n);
			end else begin
				// noise: any operation, any field values
				send_item(1'($urandom_range(1)), CB'($urandom), CB'($urandom),
					RADIUS_BITS'(($urandom_range(3) == 0) ? $urandom : $urandom_range(15)));
				useful_items++;
			end
		end
		wait_drained();
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		operation     = OP_LOAD;
		center_x      = '0;
		center_y      = '0;
		radius        = '0;
		span_stall    = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests = 0;
		hold_served   = 0;
		cycle_count   = 0;
		beats_sent    = 0;
		loads_sent    = 0;
		useful_items  = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, light idling on both sides
		send_idle_pct = 25;
		recv_idle_pct = 25;
		send_item(OP_STEP, '0, '0, '0);                   // step while idle after reset
		draw_disk(-32768, 32767, 0, 2);                   // zero radius, then a step after done
		draw_disk(32767, -32768, 1, 2);                   // one iteration disk, then idle step
		draw_disk(0, 0, 16383, 3);                        // max radius, abandoned ...
		draw_disk(-32768, -32768, 16383, 2);              // ... by this load, itself abandoned
		draw_disk(32767, 32767, 5, 6);                    // full disk at the positive corner
		draw_disk(-1, -1, 3, 4);
		wait_drained();

		// random part: sender light / receiver heavy, then swapped; a phase with no idling follows the pressure part
		random_phase(25, 77, 125);
		random_phase(77, 25, 125);

		// pressure: receiver holds off while steps keep coming, so the job
		// queue fills and item_stall rises; then a full drain
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests <= hold_requests + 1;
		draw_disk(-100, 200, 30, 24);
		wait_drained();

		random_phase(0, 0, 124);

		repeat (DRAIN_TAIL) @(posedge clk);

		$display("Run covered %0d input beats (%0d loads) and %0d checked spans,",
			beats_sent, loads_sent, span_count);
		$display("with idle steps, abandoned disks, zero and max radius, and a long output hold-off.");
		if (error_count == 0 && pending == 0) begin
			$display("filled_disk_span_generator_test passed");
		end else begin
			$display("filled_disk_span_generator_test failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		@(posedge clk);
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("%0t: timeout after %0d cycles, %0d spans still due", $time, cycle_count, pending);
		$display("filled_disk_span_generator_test failed");
		$finish;
	end

endmodule

// ===== filled_disk_span_generator.f =====
design/fdsg_pkg.sv
design/fdsg_queue.sv
design/fdsg_front.sv
design/fdsg_back.sv
design/filled_disk_span_generator.sv
sim/filled_disk_span_checker.sv
sim/filled_disk_span_generator_test.sv
